[rtl/vucd_pkg.sv]
// Package for the video update command decoder.
// Holds the decode phases, command codes, register access kinds and the
// result and queue entry types shared by the front, queue and back modules.
`default_nettype none

package vucd_pkg;

  localparam int unsigned LEFT_W  = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = 2;
  localparam int unsigned QCNT_W  = 3;

  typedef enum logic [3:0] {
    PH_CMD,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_WRITE_VAL,
    PH_FILL_COUNT,
    PH_FILL_VAL,
    PH_BLOCK_COUNT,
    PH_BLOCK_DATA,
    PH_HALTED
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ADDR   = 2'd1,
    KIND_DATA   = 2'd2
  } kind_t;

  localparam logic [BYTE_W-1:0] OP_ADDR  = 8'h00;
  localparam logic [BYTE_W-1:0] OP_WRITE = 8'h01;
  localparam logic [BYTE_W-1:0] OP_FILL  = 8'h02;
  localparam logic [BYTE_W-1:0] OP_BLOCK = 8'h03;
  localparam logic [BYTE_W-1:0] OP_END   = 8'hFF;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    logic [BYTE_W-1:0] repeat_count;
  } result_t;

  // One queue entry holds every result caused by one input item.
  typedef struct packed {
    logic    two;
    result_t res1;
    result_t res0;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

[rtl/vucd_front.sv]
// Front part of the video update command decoder: decodes list bytes.
// Turns each accepted byte into a queue entry of up to two results.
// Depends on vucd_pkg.
`default_nettype none

module vucd_front #(
  parameter int unsigned LIST_BYTES = 512
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          take,
  input  wire  [vucd_pkg::BYTE_W-1:0]  list_byte,
  input  wire  [vucd_pkg::LEFT_W-1:0]  bytes_left,
  output logic                         push,
  output vucd_pkg::job_t               job
);
  import vucd_pkg::*;

  phase_t            phase_r, phase_nxt, phase_eff;
  logic [BYTE_W-1:0] held_r, held_nxt;
  logic [BYTE_W-1:0] pend_r, pend_nxt, pend_dec;
  logic              start_r, start_nxt;
  logic [LEFT_W-1:0] left;
  result_t           body0, body1, status_res;
  logic [1:0]        nb;

  always_comb begin
    if ({{(32-LEFT_W){1'b0}}, bytes_left} > 32'(LIST_BYTES)) begin
      left = LEFT_W'(LIST_BYTES);
    end else begin
      left = bytes_left;
    end
  end

  assign phase_eff  = start_r ? PH_CMD : phase_r;
  assign status_res = '{kind: KIND_STATUS, value: '0, repeat_count: BYTE_W'(1)};
  assign pend_dec   = (pend_r != '0) ? pend_r - BYTE_W'(1) : '0;

  always_comb begin
    phase_nxt = phase_eff;
    held_nxt  = held_r;
    pend_nxt  = pend_r;
    start_nxt = 1'b0;
    nb        = 2'd0;
    body0     = '{kind: KIND_DATA, value: list_byte, repeat_count: BYTE_W'(1)};
    body1     = '{kind: KIND_ADDR, value: list_byte, repeat_count: BYTE_W'(1)};
    unique case (phase_eff)
      PH_CMD: begin
        case (list_byte)
          OP_ADDR:  phase_nxt = (left >= LEFT_W'(3)) ? PH_ADDR_HI : PH_HALTED;
          OP_WRITE: phase_nxt = (left >= LEFT_W'(2)) ? PH_WRITE_VAL : PH_HALTED;
          OP_FILL:  phase_nxt = (left >= LEFT_W'(3)) ? PH_FILL_COUNT : PH_HALTED;
          OP_BLOCK: phase_nxt = (left >= LEFT_W'(2)) ? PH_BLOCK_COUNT : PH_HALTED;
          OP_END:   phase_nxt = PH_HALTED;
          default:  phase_nxt = PH_HALTED;
        endcase
      end
      PH_ADDR_HI: begin
        held_nxt  = list_byte;
        phase_nxt = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        body0     = '{kind: KIND_ADDR, value: held_r, repeat_count: BYTE_W'(1)};
        nb        = 2'd2;
        phase_nxt = PH_CMD;
      end
      PH_WRITE_VAL: begin
        nb        = 2'd1;
        phase_nxt = PH_CMD;
      end
      PH_FILL_COUNT: begin
        pend_nxt  = list_byte;
        phase_nxt = PH_FILL_VAL;
      end
      PH_FILL_VAL: begin
        body0     = '{kind: KIND_DATA, value: list_byte, repeat_count: pend_r};
        nb        = (pend_r != '0) ? 2'd1 : 2'd0;
        pend_nxt  = '0;
        phase_nxt = PH_CMD;
      end
      PH_BLOCK_COUNT: begin
        if (left == '0 || {{(LEFT_W-BYTE_W){1'b0}}, list_byte} >= left) begin
          phase_nxt = PH_HALTED;
        end else begin
          pend_nxt  = list_byte;
          phase_nxt = (list_byte == '0) ? PH_CMD : PH_BLOCK_DATA;
        end
      end
      PH_BLOCK_DATA: begin
        nb       = 2'd1;
        pend_nxt = pend_dec;
        if (pend_dec == '0) begin
          phase_nxt = PH_CMD;
        end
      end
      PH_HALTED: phase_nxt = PH_HALTED;
      default:   phase_nxt = PH_HALTED;
    endcase
    if (left == LEFT_W'(1)) begin
      start_nxt = 1'b1;
      phase_nxt = PH_CMD;
      pend_nxt  = '0;
    end
  end

  // The status read only comes with a command byte, which itself writes nothing.
  always_comb begin
    job.res0 = start_r ? status_res : body0;
    job.res1 = body1;
    job.two  = !start_r && (nb == 2'd2);
    push     = take && (start_r || nb != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      held_r  <= '0;
      pend_r  <= '0;
      start_r <= 1'b1;
    end else if (take) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/vucd_queue.sv]
// Short queue between the decoder front and the result back.
// Register based, one entry per input item that causes results.
// Depends on vucd_pkg.
`default_nettype none

module vucd_queue (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             push,
  input  vucd_pkg::job_t  push_job,
  input  wire             pop,
  output vucd_pkg::job_t  head_job,
  output vucd_pkg::qstat_t stat
);
  import vucd_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/vucd_back.sv]
// Back part of the video update command decoder: sends out results.
// Walks the results of the queue head one per accepted output item.
// Depends on vucd_pkg.
`default_nettype none

module vucd_back (
  input  wire              clk,
  input  wire              rst_n,
  input  vucd_pkg::job_t   head_job,
  input  vucd_pkg::qstat_t stat,
  output logic             pop,
  output logic             res_valid,
  input  wire              res_ready,
  output vucd_pkg::result_t res,
  output logic             res_last
);
  import vucd_pkg::*;

  logic second_r, second_nxt;
  logic fire;

  assign res_valid = !stat.empty;
  assign fire      = res_valid && res_ready;
  assign res       = second_r ? head_job.res1 : head_job.res0;
  assign res_last  = second_r || !head_job.two;
  assign pop       = fire && res_last;

  always_comb begin
    second_nxt = second_r;
    if (fire) begin
      second_nxt = !res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/video_update_command_decoder.sv]
// Top level of the video update command decoder.
// Instantiates the decoder front, the entry queue and the result back.
// Depends on vucd_pkg, vucd_front, vucd_queue and vucd_back.
//
//   channel | direction | contents
//   in_     | input     | list byte and bytes left, one item per list byte
//   out_    | output    | register access: value, repeat count, kind, last flag
//
// An input item is taken in the cycle it arrives while the four-entry queue has room,
// and its first result can leave at the next clock edge; results go out one per cycle
// while out_tready is high. No item causes more than two results, and the address low byte
// that causes two follows the address high byte, causing none, so with the output ready
// input runs at one item per cycle. Output stalls fill the queue and then hold in_tready
// low. Reset returns the decoder to the start of a list with the queue empty.
`default_nettype none

module video_update_command_decoder #(
  parameter int unsigned LIST_BYTES = 512
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // list_byte [7:0], bytes_left [17:8], zeros above
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // write_value [7:0], repeat_count [15:8]
  output logic [1:0]  out_tuser,  // access_kind [1:0]
  output logic        out_tlast
);
  import vucd_pkg::*;

  logic    take, push, pop;
  job_t    job, head_job;
  qstat_t  stat;
  result_t res;

  assign in_tready = !stat.full;
  assign take      = in_tvalid && in_tready;

  vucd_front #(
    .LIST_BYTES(LIST_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .list_byte (in_tdata[7:0]),
    .bytes_left(in_tdata[17:8]),
    .push      (push),
    .job       (job)
  );

  vucd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(job),
    .pop     (pop),
    .head_job(head_job),
    .stat    (stat)
  );

  vucd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .stat     (stat),
    .pop      (pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res),
    .res_last (out_tlast)
  );

  assign out_tdata = {res.repeat_count, res.value};
  assign out_tuser = res.kind;

endmodule

`default_nettype wire

[verif/vucd_access_checker.sv]
// Checker for the video update command decoder: watches both stream channels,
// predicts the register accesses of every accepted list byte and compares them
// with the result items in order. Depends on vucd_pkg.
`default_nettype none

module vucd_access_checker #(
  parameter int unsigned LIST_BYTES = 512
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [23:0] in_tdata,   // list_byte [7:0], bytes_left [17:8], zeros above
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [15:0] out_tdata,  // write_value [7:0], repeat_count [15:8]
  input  wire  [1:0]  out_tuser,  // access_kind [1:0]
  input  wire         out_tlast,
  output int unsigned pending_accesses,
  output int unsigned accesses_checked,
  output int unsigned mismatches
);
  import vucd_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [7:0]  rep;
    logic        last;
  } access_t;

  access_t     access_q[$];
  access_t     byte_accesses[$];
  phase_t      phase;
  logic [7:0]  addr_high;
  logic [7:0]  count_left;
  logic        list_start;
  int unsigned n_checked;
  int unsigned n_bad;

  function automatic void add_access(kind_t k, logic [7:0] v, logic [7:0] r);
    access_t a;
    a.kind  = k;
    a.value = v;
    a.rep   = r;
    a.last  = 1'b0;
    byte_accesses.push_back(a);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic [9:0] left_in);
    logic [9:0] left;
    access_t    a;
    left = (left_in > 10'(LIST_BYTES)) ? 10'(LIST_BYTES) : left_in;
    byte_accesses.delete();
    if (list_start) begin
      add_access(KIND_STATUS, 8'h00, 8'd1);
      list_start = 1'b0;
      phase = PH_CMD;
    end
    case (phase)
      PH_CMD: begin
        if (b == OP_ADDR) phase = (left >= 10'd3) ? PH_ADDR_HI : PH_HALTED;
        else if (b == OP_WRITE) phase = (left >= 10'd2) ? PH_WRITE_VAL : PH_HALTED;
        else if (b == OP_FILL) phase = (left >= 10'd3) ? PH_FILL_COUNT : PH_HALTED;
        else if (b == OP_BLOCK) phase = (left >= 10'd2) ? PH_BLOCK_COUNT : PH_HALTED;
        else phase = PH_HALTED;
      end
      PH_ADDR_HI: begin
        addr_high = b;
        phase = PH_ADDR_LO;
      end
      PH_ADDR_LO: begin
        add_access(KIND_ADDR, addr_high, 8'd1);
        add_access(KIND_ADDR, b, 8'd1);
        phase = PH_CMD;
      end
      PH_WRITE_VAL: begin
        add_access(KIND_DATA, b, 8'd1);
        phase = PH_CMD;
      end
      PH_FILL_COUNT: begin
        count_left = b;
        phase = PH_FILL_VAL;
      end
      PH_FILL_VAL: begin
        if (count_left != 8'd0) add_access(KIND_DATA, b, count_left);
        count_left = 8'd0;
        phase = PH_CMD;
      end
      PH_BLOCK_COUNT: begin
        if (left == 10'd0 || {2'b00, b} > left - 10'd1) begin
          phase = PH_HALTED;
        end else begin
          count_left = b;
          phase = (b == 8'd0) ? PH_CMD : PH_BLOCK_DATA;
        end
      end
      PH_BLOCK_DATA: begin
        add_access(KIND_DATA, b, 8'd1);
        if (count_left != 8'd0) count_left = count_left - 8'd1;
        if (count_left == 8'd0) phase = PH_CMD;
      end
      default: phase = PH_HALTED;
    endcase
    if (left == 10'd1) begin
      list_start = 1'b1;
      phase = PH_CMD;
      count_left = 8'd0;
    end
    if (byte_accesses.size() > 0) begin
      a = byte_accesses.pop_back();
      a.last = 1'b1;
      byte_accesses.push_back(a);
    end
    foreach (byte_accesses[i]) access_q.push_back(byte_accesses[i]);
  endtask

  task automatic check_access();
    access_t want;
    if (access_q.size() == 0) begin
      n_bad++;
      $display("%0t: unexpected access, got kind %0d value %02h repeat %0d last %0b",
               $time, out_tuser, out_tdata[7:0], out_tdata[15:8], out_tlast);
    end else begin
      want = access_q.pop_front();
      n_checked++;
      if (out_tuser !== want.kind || out_tdata[7:0] !== want.value ||
          out_tdata[15:8] !== want.rep || out_tlast !== want.last) begin
        n_bad++;
        $display("%0t: mismatch, expected kind %0d value %02h repeat %0d last %0b",
                 $time, want.kind, want.value, want.rep, want.last);
        $display("%0t:           got      kind %0d value %02h repeat %0d last %0b",
                 $time, out_tuser, out_tdata[7:0], out_tdata[15:8], out_tlast);
      end
    end
  endtask

  initial begin
    n_checked = 0;
    n_bad = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = PH_CMD;
      addr_high = 8'h00;
      count_left = 8'h00;
      list_start = 1'b1;
      access_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata[7:0], in_tdata[17:8]);
      if (out_tvalid && out_tready) check_access();
    end
    pending_accesses <= access_q.size();
    accesses_checked <= n_checked;
    mismatches <= n_bad;
  end

endmodule

`default_nettype wire

[verif/tb_video_update_command_decoder.sv]
// Testbench top for the video update command decoder: drives directed and random
// command lists under four pacing phases and gives the verdict.
// Depends on vucd_pkg, the decoder RTL and vucd_access_checker.
`default_nettype none

module tb_video_update_command_decoder;
  import vucd_pkg::*;

  localparam int unsigned LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [23:0] in_tdata = 24'd0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [15:0] out_tdata;
  wire  [1:0]  out_tuser;
  wire         out_tlast;

  int unsigned pending_accesses;
  int unsigned accesses_checked;
  int unsigned mismatches;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycles = 0;
  int          list_items = 0;
  int          noise_items = 0;
  logic [7:0]  list_bytes[$];

  int idle_tab[4]  = '{0, 66, 0, 38};
  int stall_tab[4] = '{0, 0, 66, 38};

  video_update_command_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  vucd_access_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .pending_accesses(pending_accesses), .accesses_checked(accesses_checked),
    .mismatches(mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic [9:0] left);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, left, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_accesses != 0) @(posedge clk);
  endtask

  task automatic build_list();
    int ncmd;
    int sel;
    int cnt;
    list_bytes.delete();
    ncmd = $urandom_range(6, 1);
    repeat (ncmd) begin
      sel = $urandom_range(99);
      if (sel < 22) begin
        list_bytes.push_back(OP_ADDR);
        list_bytes.push_back(8'($urandom_range(255)));
        list_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 42) begin
        list_bytes.push_back(OP_WRITE);
        list_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 62) begin
        sel = $urandom_range(99);
        cnt = (sel < 8) ? 0 : (sel < 16) ? 255 : $urandom_range(30, 1);
        list_bytes.push_back(OP_FILL);
        list_bytes.push_back(8'(cnt));
        list_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 92) begin
        sel = $urandom_range(99);
        cnt = (sel < 8) ? 0 : (sel < 10) ? $urandom_range(255, 100) : $urandom_range(10, 1);
        list_bytes.push_back(OP_BLOCK);
        list_bytes.push_back(8'(cnt));
        repeat (cnt) list_bytes.push_back(8'($urandom_range(255)));
      end else begin
        list_bytes.push_back((sel < 96) ? OP_END : 8'($urandom_range(254, 4)));
        repeat ($urandom_range(3)) list_bytes.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Most lists are sent with true byte counts; the rest are cut short, end in
  // the middle of a command, or carry counts far above the list size.
  task automatic play_list(input bit consistent);
    int len;
    int cut;
    int offs;
    int mode;
    int v;
    len = list_bytes.size();
    mode = consistent ? 0 : $urandom_range(99);
    cut = len;
    offs = 0;
    if (mode >= 70 && mode < 90) cut = $urandom_range(len, 1);
    if (mode >= 90) offs = $urandom_range(1023, 1);
    for (int i = 0; i < cut; i++) begin
      if (mode < 80) v = cut - i;
      else if (i == cut - 1) v = 1;
      else v = len - i + offs;
      if (v > 1023) v = 1023;
      send_item(list_bytes[i], 10'(v));
      list_items++;
    end
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    list_bytes = {OP_ADDR, 8'hAB, 8'hCD};
    play_list(1'b1);
    list_bytes = {OP_WRITE, 8'hFF};
    play_list(1'b1);
    list_bytes = {OP_FILL, 8'hFF, 8'h5A, OP_FILL, 8'h00, 8'h77};
    play_list(1'b1);
    list_bytes = {OP_BLOCK, 8'h02, 8'h11, 8'h22, OP_BLOCK, 8'h00};
    play_list(1'b1);
    list_bytes = {OP_END, OP_WRITE};
    play_list(1'b1);
    list_bytes = {8'h80, 8'h00};
    play_list(1'b1);
    send_item(OP_ADDR, 10'd1);
    list_bytes = {OP_BLOCK, 8'h05};
    play_list(1'b1);
    send_item(OP_WRITE, 10'd0);
    send_item(OP_WRITE, 10'd1);
    send_item(OP_WRITE, 10'h3FF);
    send_item(8'h42, 10'd1);
    list_items += 5;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      target = list_items + 400;
      while (list_items < target) begin
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(3, 1)) begin
            send_item(8'($urandom_range(255)), 10'($urandom_range(1023)));
            noise_items++;
          end
        end else begin
          build_list();
          play_list(1'b0);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d list bytes and %0d noise bytes over four pacing phases.",
             list_items, noise_items);
    $display("Checked %0d register accesses; %0d mismatched.", accesses_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
